@@ rtl/imh_pkg.sv @@
package imh_pkg;

    localparam int CAPACITY   = 256;
    localparam int POS_BITS   = 8;
    localparam int COUNT_BITS = 9;
    localparam int KEY_BITS   = 32;
    localparam int VTX_BITS   = 8;
    localparam int VTX_COUNT  = 256;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;
    localparam logic [1:0] CMD_QUERY    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    localparam logic [COUNT_BITS-1:0] POS_ABSENT = COUNT_BITS'(CAPACITY);

    typedef struct packed {
        logic [VTX_BITS-1:0] vtx;
        logic [KEY_BITS-1:0] key;
    } entry_t;

endpackage

@@ rtl/indexed_min_heap_decrease_key_top.sv @@
// channel  | ports                                         | direction
// request  | s_valid s_ready s_cmd s_vertex s_key_value    | in
// result   | m_valid m_ready m_status m_vertex_out m_key_out| out
//          | m_present m_count_out                         |
// a query or an error passes the position lookup and the done state before the
// next request is taken; insert and decrease walk up one heap level a step (read
// parent, compare and write back), up to 8 levels; extract walks down one level
// a step (read left, read right, compare and write back), up to 7 levels; the
// single heap memory read port sets the pace.
// after reset a clearing pass marks every vertex absent; no request is taken
// meanwhile. a held result keeps the next finished request waiting in the done
// state until the output register frees.
module indexed_min_heap_decrease_key_top
    import imh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [VTX_BITS-1:0]   s_vertex,
    input  logic [KEY_BITS-1:0]   s_key_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [VTX_BITS-1:0]   m_vertex_out,
    output logic [KEY_BITS-1:0]   m_key_out,
    output logic                  m_present,
    output logic [COUNT_BITS-1:0] m_count_out
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_XRD   = 4'd4;
    localparam logic [3:0] S_XLAST = 4'd5;
    localparam logic [3:0] S_UPRD  = 4'd6;
    localparam logic [3:0] S_UPCMP = 4'd7;
    localparam logic [3:0] S_DNRD  = 4'd8;
    localparam logic [3:0] S_DNR   = 4'd9;
    localparam logic [3:0] S_DNCMP = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_XROOT = 4'd12;

    // memories
    entry_t              heap_mem [CAPACITY];
    logic [COUNT_BITS-1:0] pos_mem [VTX_COUNT];

    logic                  h_we;
    logic [POS_BITS-1:0]   h_waddr, h_raddr;
    entry_t                h_wdata, h_rdata;
    logic                  p_we;
    logic [VTX_BITS-1:0]   p_waddr, p_raddr;
    logic [COUNT_BITS-1:0] p_wdata, p_rdata;

    always_ff @(posedge aclk) begin
        if (h_we) heap_mem[h_waddr] <= h_wdata;
        h_rdata <= heap_mem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) pos_mem[p_waddr] <= p_wdata;
        p_rdata <= pos_mem[p_raddr];
    end

    logic [3:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [POS_BITS-1:0]   clr_reg, clr_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [VTX_BITS-1:0]   vtx_reg, vtx_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    entry_t                cur_reg, cur_next;     // entry being sifted
    entry_t                oth_reg, oth_next;     // left child during a sift-down
    logic [POS_BITS-1:0]   idx_reg, idx_next;
    logic [2:0]            st_reg, st_next;
    entry_t                res_reg, res_next;
    logic                  pres_reg, pres_next;
    logic                  mv_reg, mv_next;
    logic [2:0]            o_status_reg, o_status_next;
    entry_t                o_res_reg, o_res_next;
    logic                  o_pres_reg, o_pres_next;
    logic [COUNT_BITS-1:0] o_count_reg, o_count_next;

    logic [POS_BITS-1:0]   parent, lchild;
    logic [COUNT_BITS:0]   l_full, r_full;
    assign parent = (idx_reg - POS_BITS'(1)) >> 1;
    assign l_full = {idx_reg, 1'b1} + (COUNT_BITS+1)'(0);
    assign r_full = {1'b0, idx_reg, 1'b0} + (COUNT_BITS+1)'(2);
    assign lchild = l_full[POS_BITS-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_status = o_status_reg;
    assign m_vertex_out = o_res_reg.vtx;
    assign m_key_out = o_res_reg.key;
    assign m_present = o_pres_reg;
    assign m_count_out = o_count_reg;

    // command sequencer
    always_comb begin
        state_next = state_reg; count_next = count_reg; clr_next = clr_reg;
        cmd_next = cmd_reg; vtx_next = vtx_reg; key_next = key_reg;
        cur_next = cur_reg; oth_next = oth_reg; idx_next = idx_reg;
        st_next = st_reg; res_next = res_reg; pres_next = pres_reg;
        mv_next = mv_reg;
        o_status_next = o_status_reg; o_res_next = o_res_reg;
        o_pres_next = o_pres_reg; o_count_next = o_count_reg;
        h_we = 1'b0; h_waddr = '0; h_wdata = cur_reg; h_raddr = idx_reg;
        p_we = 1'b0; p_waddr = cur_reg.vtx; p_wdata = {1'b0, idx_reg};
        p_raddr = s_vertex;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1; p_waddr = clr_reg; p_wdata = POS_ABSENT;
                clr_next = clr_reg + POS_BITS'(1);
                if (clr_reg == POS_BITS'(VTX_COUNT - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                h_raddr = '0;
                if (s_valid && s_ready) begin
                    cmd_next = s_cmd; vtx_next = s_vertex; key_next = s_key_value;
                    st_next = ST_OK; res_next = '0; pres_next = 1'b0;
                    state_next = S_POS;
                end
            end
            S_POS: begin
                // position of the vertex is in p_rdata, root in h_rdata
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (count_reg >= COUNT_BITS'(CAPACITY)) begin
                            st_next = ST_FULL; state_next = S_DONE;
                        end else if (p_rdata < count_reg) begin
                            st_next = ST_PRESENT; state_next = S_DONE;
                        end else begin
                            idx_next = count_reg[POS_BITS-1:0];
                            cur_next = '{vtx: vtx_reg, key: key_reg};
                            count_next = count_reg + COUNT_BITS'(1);
                            state_next = S_UPRD;
                        end
                    end
                    CMD_EXTRACT: begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY; state_next = S_DONE;
                        end else begin
                            res_next = h_rdata;
                            state_next = S_XRD;
                        end
                    end
                    CMD_DECREASE: begin
                        if (!(p_rdata < count_reg)) begin
                            st_next = ST_ABSENT; state_next = S_DONE;
                        end else begin
                            idx_next = p_rdata[POS_BITS-1:0];
                            cur_next = '{vtx: vtx_reg, key: key_reg};
                            state_next = S_UPRD;
                        end
                    end
                    default: begin
                        pres_next = p_rdata < count_reg;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_XRD: begin
                // mark extracted vertex absent, fetch last entry
                p_we = 1'b1; p_waddr = res_reg.vtx; p_wdata = POS_ABSENT;
                h_raddr = POS_BITS'(count_reg - COUNT_BITS'(1));
                count_next = count_reg - COUNT_BITS'(1);
                state_next = S_XLAST;
            end
            S_XLAST: begin
                cur_next = h_rdata; idx_next = '0;
                state_next = (count_reg == '0) ? S_DONE : S_XROOT;
            end
            S_XROOT: begin
                state_next = S_DNRD;
            end
            S_DNRD: begin
                // read left child
                h_raddr = lchild;
                if (l_full >= {1'b0, count_reg}) begin
                    h_we = 1'b1; h_waddr = idx_reg; p_we = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DNR;
                end
            end
            S_DNR: begin
                oth_next = h_rdata;
                h_raddr = lchild + POS_BITS'(1);
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                // left wins ties; entry moves only on strict less
                if (r_full < {1'b0, count_reg} && h_rdata.key < oth_reg.key
                        && h_rdata.key < cur_reg.key) begin
                    h_we = 1'b1; h_waddr = idx_reg; h_wdata = h_rdata;
                    p_we = 1'b1; p_waddr = h_rdata.vtx;
                    idx_next = lchild + POS_BITS'(1);
                    state_next = S_DNRD;
                end else if (oth_reg.key < cur_reg.key) begin
                    h_we = 1'b1; h_waddr = idx_reg; h_wdata = oth_reg;
                    p_we = 1'b1; p_waddr = oth_reg.vtx;
                    idx_next = lchild;
                    state_next = S_DNRD;
                end else begin
                    h_we = 1'b1; h_waddr = idx_reg; p_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_UPRD: begin
                h_raddr = parent;
                if (idx_reg == '0) begin
                    h_we = 1'b1; h_waddr = idx_reg; p_we = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (cur_reg.key < h_rdata.key) begin
                    h_we = 1'b1; h_waddr = idx_reg; h_wdata = h_rdata;
                    p_we = 1'b1; p_waddr = h_rdata.vtx;
                    idx_next = parent;
                    state_next = S_UPRD;
                end else begin
                    h_we = 1'b1; h_waddr = idx_reg; p_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!mv_reg || m_ready) begin
                    o_status_next = st_reg; o_res_next = res_reg;
                    o_pres_next = pres_reg; o_count_next = count_reg;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg <= clr_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next; vtx_reg <= vtx_next; key_reg <= key_next;
        cur_reg <= cur_next; oth_reg <= oth_next; idx_reg <= idx_next;
        st_reg <= st_next; res_reg <= res_next; pres_reg <= pres_next;
        o_status_reg <= o_status_next; o_res_reg <= o_res_next;
        o_pres_reg <= o_pres_next; o_count_reg <= o_count_next;
    end

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_BITS'(CAPACITY)) else $error("count overflow");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable({m_status, m_vertex_out,
        m_key_out, m_present, m_count_out}))) else $error("result changed while held");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("count changed in idle");

endmodule
